// ===== rtl/tpa_pkg.sv =====
package tpa_pkg;

  localparam int ADDR_W      = 40;
  localparam int PIDX_W      = 16;
  localparam int KCNT_W      = 15;
  localparam int TCNT_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ADDR_W-1:0] BASE_AT_RESET   = 40'h00_8000_0000;
  localparam logic [KCNT_W-1:0] KPAGES_AT_RESET = 15'd1024;
  localparam logic [TCNT_W-1:0] TPAGES_AT_RESET = 16'd32768;

  typedef logic [PIDX_W-1:0] pidx_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_EXHAUSTED  = 2'd1,
    STAT_MISALIGNED = 2'd2,
    STAT_OUTSIDE    = 2'd3
  } status_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_BASE  = 2'd0,
    CFG_KERNEL_COUNT = 2'd1,
    CFG_TOTAL_COUNT  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    pidx_t             kpages;
    pidx_t             tpages;
  } cfg_view_t;

  typedef struct packed {
    func_t   func;
    logic    kern;
    status_t status;
    pidx_t   idx;
  } req_t;

endpackage

// ===== rtl/two_region_page_allocator.sv =====
// Each request is written into the queue, then popped by the back end into the output register.
// Throughput: one request per cycle while the output is not stalled, except an allocation
// that pops a freed page, which holds the back end while the next-page memory is read.
// Reset is synchronous and active low; the free lists are rebuilt in the cycle after
// reset or after a write to the base, kernel-count or total-count register; the next-page memory is not cleared.
module two_region_page_allocator #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic                           in_in_kernel,
  input  logic [tpa_pkg::ADDR_W-1:0]     in_page_addr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tpa_pkg::ADDR_W-1:0]     out_granted_addr,
  output logic [1:0]                     out_status,
  input  logic                           cfg_wr_en,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpa_pkg::ADDR_W-1:0]     cfg_wdata
);
  import tpa_pkg::*;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [KCNT_W-1:0] kcount_r, kcount_nxt;
  logic [TCNT_W-1:0] tcount_r, tcount_nxt;
  logic              reinit_r, reinit_nxt;

  cfg_view_t         cfg;
  pidx_t             tot_eff;
  req_t              fq_data;
  req_t              qb_data;
  logic              q_wr;
  logic              q_rd;
  logic              q_full;
  logic              q_empty;

  always_comb begin
    base_nxt   = base_r;
    kcount_nxt = kcount_r;
    tcount_nxt = tcount_r;
    reinit_nxt = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_REGION_BASE: begin
          base_nxt   = cfg_wdata;
          reinit_nxt = 1'b1;
        end
        CFG_KERNEL_COUNT: begin
          kcount_nxt = cfg_wdata[KCNT_W-1:0];
          reinit_nxt = 1'b1;
        end
        CFG_TOTAL_COUNT: begin
          tcount_nxt = cfg_wdata[TCNT_W-1:0];
          reinit_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_AT_RESET;
      kcount_r <= KPAGES_AT_RESET;
      tcount_r <= TPAGES_AT_RESET;
      reinit_r <= 1'b1;
    end else begin
      base_r   <= base_nxt;
      kcount_r <= kcount_nxt;
      tcount_r <= tcount_nxt;
      reinit_r <= reinit_nxt;
    end
  end

  always_comb begin
    tot_eff    = ({1'b0, tcount_r} > (TCNT_W + 1)'(MAX_PAGES)) ? PIDX_W'(MAX_PAGES)
                                                               : tcount_r;
    cfg.tpages = tot_eff;
    cfg.kpages = ({1'b0, kcount_r} > tot_eff) ? tot_eff : {1'b0, kcount_r};
    cfg.base   = base_r & ~ADDR_W'(PAGE_BYTES - 1);
  end

  tpa_front #(
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_in_kernel (in_in_kernel),
    .in_page_addr (in_page_addr),
    .cfg          (cfg),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_data       (fq_data)
  );

  tpa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (fq_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (qb_data),
    .empty   (q_empty)
  );

  tpa_back #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .reinit           (reinit_r),
    .q_data           (qb_data),
    .q_empty          (q_empty),
    .q_rd             (q_rd),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_addr (out_granted_addr),
    .out_status       (out_status)
  );

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |-> !q_full)
    else $error("queue written while full");

  a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_empty)
    else $error("queue read while empty");

  a_no_pop_during_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    reinit_r |-> !q_rd)
    else $error("request executed while free lists are rebuilt");

  a_error_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_granted_addr == '0))
    else $error("non-zero address on an error result");

endmodule

// ===== rtl/tpa_front.sv =====
module tpa_front #(
  parameter int PAGE_SHIFT = 12
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic                        in_in_kernel,
  input  logic [tpa_pkg::ADDR_W-1:0]  in_page_addr,
  input  tpa_pkg::cfg_view_t          cfg,
  input  logic                        q_full,
  output logic                        q_wr,
  output tpa_pkg::req_t               q_data
);
  import tpa_pkg::*;

  localparam int IDXW = ADDR_W - PAGE_SHIFT;

  pidx_t           lo;
  pidx_t           hi;
  logic [ADDR_W:0] off;
  logic [IDXW-1:0] idx_full;
  logic            misaligned;
  logic            outside;

  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;

  always_comb begin
    lo         = in_in_kernel ? '0 : cfg.kpages;
    hi         = in_in_kernel ? cfg.kpages : cfg.tpages;
    off        = {1'b0, in_page_addr} - {1'b0, cfg.base};
    idx_full   = off[ADDR_W-1:PAGE_SHIFT];
    misaligned = |in_page_addr[PAGE_SHIFT-1:0];
    outside    = off[ADDR_W] || (idx_full < IDXW'(lo)) || (idx_full >= IDXW'(hi));

    q_data.func = func_t'(in_func);
    q_data.kern = in_in_kernel;
    q_data.idx  = idx_full[PIDX_W-1:0];
    if (q_data.func == FUNC_ALLOC) begin
      q_data.status = STAT_OK;
    end else if (misaligned) begin
      q_data.status = STAT_MISALIGNED;
    end else if (outside) begin
      q_data.status = STAT_OUTSIDE;
    end else begin
      q_data.status = STAT_OK;
    end
  end

endmodule

// ===== rtl/tpa_queue.sv =====
module tpa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  tpa_pkg::req_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output tpa_pkg::req_t rd_data,
  output logic          empty
);
  import tpa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  req_t             entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full    = count_r == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign rd_data = entries_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (wr_en) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (rd_en) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/tpa_back.sv =====
module tpa_back #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tpa_pkg::cfg_view_t          cfg,
  input  logic                        reinit,
  input  tpa_pkg::req_t               q_data,
  input  logic                        q_empty,
  output logic                        q_rd,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tpa_pkg::ADDR_W-1:0]  out_granted_addr,
  output logic [1:0]                  out_status
);
  import tpa_pkg::*;

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  typedef enum logic [1:0] {
    BK_RUN  = 2'b01,
    BK_LINK = 2'b10
  } bk_state_t;

  bk_state_t         state_r, state_nxt;
  pidx_t             khead_r, khead_nxt;
  pidx_t             uhead_r, uhead_nxt;
  pidx_t             kfresh_r, kfresh_nxt;
  pidx_t             ufresh_r, ufresh_nxt;
  logic              link_kern_r, link_kern_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_granted_r, out_granted_nxt;
  status_t           out_status_r, out_status_nxt;

  pidx_t             mem [MAX_PAGES];
  pidx_t             rd_data_r;
  logic              mem_rd;
  logic              mem_wr;
  logic [AW-1:0]     mem_rd_addr;
  logic [AW-1:0]     mem_wr_addr;
  pidx_t             mem_wr_data;

  pidx_t             head;
  pidx_t             fresh;
  pidx_t             lo;
  pidx_t             hi;
  pidx_t             new_head;
  pidx_t             new_fresh;
  logic              out_free;

  assign out_valid        = out_valid_r;
  assign out_granted_addr = out_granted_r;
  assign out_status       = out_status_r;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    q_rd     = (state_r == BK_RUN) && !reinit && !q_empty && out_free;

    head  = q_data.kern ? khead_r : uhead_r;
    fresh = q_data.kern ? kfresh_r : ufresh_r;
    lo    = q_data.kern ? '0 : cfg.kpages;
    hi    = q_data.kern ? cfg.kpages : cfg.tpages;

    state_nxt       = state_r;
    khead_nxt       = khead_r;
    uhead_nxt       = uhead_r;
    kfresh_nxt      = kfresh_r;
    ufresh_nxt      = ufresh_r;
    link_kern_nxt   = link_kern_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    new_head        = head;
    new_fresh       = fresh;
    mem_rd          = 1'b0;
    mem_wr          = 1'b0;
    mem_rd_addr     = head[AW-1:0];
    mem_wr_addr     = q_data.idx[AW-1:0];
    mem_wr_data     = head;

    if (reinit) begin
      khead_nxt  = '0;
      kfresh_nxt = '0;
      uhead_nxt  = cfg.kpages;
      ufresh_nxt = cfg.kpages;
      state_nxt  = BK_RUN;
    end else if (state_r == BK_LINK) begin
      if (link_kern_r) begin
        khead_nxt = rd_data_r;
      end else begin
        uhead_nxt = rd_data_r;
      end
      state_nxt = BK_RUN;
    end else if (q_rd) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = '0;
      out_status_nxt  = q_data.status;
      if (q_data.func == FUNC_ALLOC) begin
        if ((head >= hi) || (head < lo)) begin
          out_status_nxt = STAT_EXHAUSTED;
        end else begin
          out_status_nxt  = STAT_OK;
          out_granted_nxt = cfg.base + (ADDR_W'(head) << PAGE_SHIFT);
          if (head == fresh) begin
            new_head  = head + 1'b1;
            new_fresh = head + 1'b1;
          end else begin
            mem_rd        = 1'b1;
            state_nxt     = BK_LINK;
            link_kern_nxt = q_data.kern;
          end
        end
      end else if (q_data.status == STAT_OK) begin
        mem_wr   = 1'b1;
        new_head = q_data.idx;
      end
      if (q_data.kern) begin
        khead_nxt  = new_head;
        kfresh_nxt = new_fresh;
      end else begin
        uhead_nxt  = new_head;
        ufresh_nxt = new_fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    khead_r       <= khead_nxt;
    uhead_r       <= uhead_nxt;
    kfresh_r      <= kfresh_nxt;
    ufresh_r      <= ufresh_nxt;
    link_kern_r   <= link_kern_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd) begin
      rd_data_r <= mem[mem_rd_addr];
    end
  end

endmodule
